// ===== src/iida_pkg.sv =====
// ----------------------------------------------------------------------------
// iida_pkg
// Shared types and constants for the indexed insert/delete array: operation
// and status codes, word layouts and the per-cell control bundle.
// ----------------------------------------------------------------------------
package iida_pkg;

    // fixed field widths of the request and response words
    localparam int FUNC_W   = 2;
    localparam int POS_W    = 7;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    // index width wide enough for any supported depth and its count
    localparam int IDX_W    = 11;
    // widest supported element width
    localparam int WIDE_W   = 64;

    typedef enum logic [FUNC_W-1:0] {
        OP_APPEND = 2'd0,
        OP_INSERT = 2'd1,
        OP_DELETE = 2'd2,
        OP_READ   = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE   = 2'd0,
        ST_FULL   = 2'd1,
        ST_BADIDX = 2'd2
    } status_t;

    // action broadcast to every cell for one accepted word
    typedef enum logic [2:0] {
        ACT_HOLD   = 3'd0,
        ACT_APPEND = 3'd1,
        ACT_INSERT = 3'd2,
        ACT_DELETE = 3'd3,
        ACT_READ   = 3'd4
    } cell_act_t;

    typedef struct packed {
        cell_act_t        action;
        logic [IDX_W-1:0] pos;
        logic [IDX_W-1:0] count;
    } cell_ctrl_t;

    typedef struct packed {
        op_t                       func;
        logic [POS_W-1:0]          position;
        logic signed [VALUE_W-1:0] value;
    } req_word_t;

    typedef struct packed {
        status_t                   status;
        logic signed [VALUE_W-1:0] read_value;
        logic [COUNT_W-1:0]        element_count;
    } rsp_word_t;

endpackage

// ===== src/iida_stream_if.sv =====
// ----------------------------------------------------------------------------
// iida_stream_if
// Valid/ready channel carrying one word of a given payload type.
// ----------------------------------------------------------------------------
interface iida_stream_if #(
    parameter type T = logic
) ();

    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

// ===== src/iida_cell.sv =====
// ----------------------------------------------------------------------------
// iida_cell
// One storage slot of the list. Compares its own index with the requested
// position and count, then loads a new value, takes its lower or upper
// neighbor, or holds. Also presents its value when it is the read target.
// ----------------------------------------------------------------------------
module iida_cell
    import iida_pkg::*;
#(
    parameter int INDEX      = 0,
    parameter int DATA_WIDTH = 32
) (
    input  logic                  clk,
    input  cell_ctrl_t            ctrl,
    input  logic [DATA_WIDTH-1:0] value,
    input  logic [DATA_WIDTH-1:0] lower,
    input  logic [DATA_WIDTH-1:0] upper,
    output logic [DATA_WIDTH-1:0] data,
    output logic [DATA_WIDTH-1:0] hit_data
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;

    // next slot contents
    always_comb
    begin
        data_next = data_reg;
        case (ctrl.action)
            ACT_APPEND:
            begin
                if (MY_IDX == ctrl.count)
                    data_next = value;
            end
            ACT_INSERT:
            begin
                if (MY_IDX == ctrl.pos)
                    data_next = value;
                else if (MY_IDX > ctrl.pos && MY_IDX <= ctrl.count)
                    data_next = lower;
            end
            ACT_DELETE:
            begin
                if (MY_IDX >= ctrl.pos && (MY_IDX + 1'b1) < ctrl.count)
                    data_next = upper;
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    // slot storage, payload only
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    // read tap, zero unless this slot is addressed
    assign hit_data = (ctrl.action == ACT_READ && MY_IDX == ctrl.pos) ? data_reg : '0;
    assign data     = data_reg;

endmodule

// ===== src/indexed_insert_delete_array_core.sv =====
// ----------------------------------------------------------------------------
// indexed_insert_delete_array_core
// Ordered list of signed values in a row of storage cells with an element
// count. Append, insert at index, delete at index and read at index.
// ----------------------------------------------------------------------------
//
//   channel  dir  payload                                  word type
//   -------  ---  ---------------------------------------  ----------
//   req      in   func, position, value                    req_word_t
//   rsp      out  status, read_value, element_count        rsp_word_t
//
// All cells compare their index with the position and shift in parallel, so a
// new word is taken every cycle while the response register is empty or draining.
// The response sits in an output register in the cycle after acceptance; req is
// ready whenever that register is empty or being drained by rsp.
// Reset clears the count and the response valid; cell contents are not reset
// and only slots below the count are ever read.
//
module indexed_insert_delete_array_core
    import iida_pkg::*;
#(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    iida_stream_if.sink   req,
    iida_stream_if.source rsp
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [IDX_W-1:0] DEPTH_IDX = IDX_W'(DEPTH);

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          rsp_valid_reg;
    rsp_word_t     rsp_data_reg;
    rsp_word_t     rsp_data_next;

    logic                  accept;
    logic [IDX_W-1:0]      count_ext;
    logic [IDX_W-1:0]      pos_ext;
    logic [IDX_W-1:0]      count_next_ext;
    status_t               status;
    cell_ctrl_t            ctrl;
    logic [WIDE_W-1:0]     val_wide;
    logic [DATA_WIDTH-1:0] val_cell;
    logic [DATA_WIDTH-1:0] rd_or;
    logic [WIDE_W-1:0]     rd_wide;

    logic [DATA_WIDTH-1:0] cell_data [DEPTH];
    logic [DATA_WIDTH-1:0] cell_hit  [DEPTH];

    // handshake
    assign accept    = req.valid && req.ready;
    assign req.ready = !rsp_valid_reg || rsp.ready;

    assign count_ext = IDX_W'(count_reg);
    assign pos_ext   = IDX_W'(req.data.position);

    // fit the 32-bit signed value to the element width
    assign val_wide = WIDE_W'(req.data.value);
    assign val_cell = val_wide[DATA_WIDTH-1:0];

    // status and cell action
    always_comb
    begin
        status      = ST_DONE;
        ctrl.action = ACT_HOLD;
        ctrl.pos    = pos_ext;
        ctrl.count  = count_ext;
        unique case (req.data.func)
            OP_APPEND:
            begin
                if (count_ext >= DEPTH_IDX)
                    status = ST_FULL;
                else
                    ctrl.action = ACT_APPEND;
            end
            OP_INSERT:
            begin
                if (pos_ext > count_ext)
                    status = ST_BADIDX;
                else if (count_ext >= DEPTH_IDX)
                    status = ST_FULL;
                else
                    ctrl.action = ACT_INSERT;
            end
            OP_DELETE:
            begin
                if (pos_ext >= count_ext)
                    status = ST_BADIDX;
                else
                    ctrl.action = ACT_DELETE;
            end
            OP_READ:
            begin
                if (pos_ext >= count_ext)
                    status = ST_BADIDX;
                else
                    ctrl.action = ACT_READ;
            end
            default:
            begin
                status = ST_DONE;
            end
        endcase
        if (!accept)
            ctrl.action = ACT_HOLD;
    end

    // row of cells, each handing data to its neighbors
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [DATA_WIDTH-1:0] lower;
        logic [DATA_WIDTH-1:0] upper;

        if (i == 0)
        begin : g_first
            assign lower = '0;
        end
        else
        begin : g_mid_lo
            assign lower = cell_data[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign upper = '0;
        end
        else
        begin : g_mid_hi
            assign upper = cell_data[i+1];
        end

        iida_cell #(
            .INDEX      (i),
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .clk      (clk),
            .ctrl     (ctrl),
            .value    (val_cell),
            .lower    (lower),
            .upper    (upper),
            .data     (cell_data[i]),
            .hit_data (cell_hit[i])
        );
    end

    // collect the addressed slot, at most one tap is nonzero
    always_comb
    begin
        rd_or = '0;
        for (int i = 0; i < DEPTH; i++)
            rd_or = rd_or | cell_hit[i];
    end

    always_comb
    begin
        rd_wide                 = '0;
        rd_wide[DATA_WIDTH-1:0] = rd_or;
    end

    // new count
    always_comb
    begin
        count_next = count_reg;
        case (ctrl.action)
            ACT_APPEND, ACT_INSERT: count_next = count_reg + 1'b1;
            ACT_DELETE:             count_next = count_reg - 1'b1;
            default:                count_next = count_reg;
        endcase
    end

    assign count_next_ext = IDX_W'(count_next);

    always_comb
    begin
        rsp_data_next.status        = status;
        rsp_data_next.read_value    = rd_wide[VALUE_W-1:0];
        rsp_data_next.element_count = count_next_ext[COUNT_W-1:0];
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (accept)
                rsp_valid_reg <= 1'b1;
            else if (rsp.ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    // response payload
    always_ff @(posedge clk)
    begin
        if (accept)
            rsp_data_reg <= rsp_data_next;
    end

    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_data_reg;

    // checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("element count above depth");

    a_rsp_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> rsp.valid)
        else $error("accepted word gave no response");

    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(count_reg))
        else $error("count changed without an accepted word");

    a_full_only_at_depth: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.data.status == ST_FULL |-> count_reg == CW'(DEPTH))
        else $error("full status below depth");

    a_read_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.data.status != ST_DONE |-> rsp.data.read_value == '0)
        else $error("failed word carries read data");

endmodule

// ===== dv/indexed_insert_delete_array_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_insert_delete_array_core_tb
// Self-checking bench for the indexed insert/delete array. A scoreboard
// object keeps its own copy of the list, predicts the response for every
// accepted request word and compares each response word field by field.
// Directed words cover the empty list, bad indexes and value extremes.
// Random phases then grow the list into the full store, shrink it back to
// empty and mix operations, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module indexed_insert_delete_array_core_tb
    import iida_pkg::*;
();

    localparam int DEPTH        = 64;
    localparam int DATA_WIDTH   = 32;
    localparam int RANDOM_WORDS = 1700;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int TAIL_CYCLES  = 8;

    // shadow list and queue of predicted response words
    class list_scoreboard;
        logic signed [VALUE_W-1:0] cells [DEPTH];
        int                        len;
        rsp_word_t                 awaited_q [$];
        int                        errors;

        function new();
            len    = 0;
            errors = 0;
        endfunction

        function int pending();
            return awaited_q.size();
        endfunction

        // apply one accepted request word to the shadow list
        function void note_request(req_word_t w);
            rsp_word_t e;
            int        i;
            int        p;
            e.status     = ST_DONE;
            e.read_value = '0;
            p            = int'(w.position);
            case (w.func)
                OP_APPEND:
                begin
                    if (len >= DEPTH)
                        e.status = ST_FULL;
                    else
                    begin
                        cells[len] = w.value;
                        len++;
                    end
                end
                OP_INSERT:
                begin
                    // index check comes before fullness
                    if (p > len)
                        e.status = ST_BADIDX;
                    else if (len >= DEPTH)
                        e.status = ST_FULL;
                    else
                    begin
                        for (i = len; i > p; i--)
                            cells[i] = cells[i-1];
                        cells[p] = w.value;
                        len++;
                    end
                end
                OP_DELETE:
                begin
                    if (p >= len)
                        e.status = ST_BADIDX;
                    else
                    begin
                        for (i = p; i + 1 < len; i++)
                            cells[i] = cells[i+1];
                        len--;
                    end
                end
                default:
                begin
                    if (p >= len)
                        e.status = ST_BADIDX;
                    else
                        e.read_value = cells[p];
                end
            endcase
            e.element_count = COUNT_W'(len);
            awaited_q.push_back(e);
        endfunction

        // compare one response word with the oldest prediction
        function void check_response(rsp_word_t r);
            rsp_word_t e;
            if (awaited_q.size() == 0)
            begin
                $error("response word with nothing awaited: status %0d value %0d count %0d",
                       r.status, r.read_value, r.element_count);
                errors++;
                return;
            end
            e = awaited_q.pop_front();
            if (r.status !== e.status)
            begin
                $error("status mismatch: expected %0d, actual %0d", e.status, r.status);
                errors++;
            end
            if (r.read_value !== e.read_value)
            begin
                $error("read_value mismatch: expected %0d, actual %0d",
                       e.read_value, r.read_value);
                errors++;
            end
            if (r.element_count !== e.element_count)
            begin
                $error("element_count mismatch: expected %0d, actual %0d",
                       e.element_count, r.element_count);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   calm;
    int   cycle_count;

    iida_stream_if #(.T(req_word_t)) req_if ();
    iida_stream_if #(.T(rsp_word_t)) rsp_if ();

    list_scoreboard sb = new();

    indexed_insert_delete_array_core #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // watch both channels
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_if.valid && req_if.ready)
                sb.note_request(req_if.data);
            if (rsp_if.valid && rsp_if.ready)
                sb.check_response(rsp_if.data);
        end
    end

    // response side stalls now and then
    initial
    begin
        rsp_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (!rst_n)
                rsp_if.ready <= 1'b0;
            else
                rsp_if.ready <= calm || ($urandom_range(0, 99) >= 15);
        end
    end

    // hold one request word until it is taken
    task automatic send_word(req_word_t w);
        req_if.valid <= 1'b1;
        req_if.data  <= w;
        do
            @(posedge clk);
        while (!req_if.ready);
    endtask

    task automatic idle_sender(int n);
        req_if.valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // one word, then maybe a gap
    task automatic issue(op_t f, int p, logic [VALUE_W-1:0] v);
        req_word_t w;
        w.func     = f;
        w.position = POS_W'(p);
        w.value    = v;
        send_word(w);
        if (!calm && $urandom_range(0, 99) < 15)
            idle_sender($urandom_range(1, 2));
    endtask

    task automatic wait_drained();
        idle_sender(1);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    function automatic logic [VALUE_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 2)
            return 32'h8000_0000;
        else if (r < 4)
            return 32'h7FFF_FFFF;
        else if (r < 6)
            return 32'hFFFF_FFFF;
        else if (r < 8)
            return 32'h0000_0000;
        return $urandom;
    endfunction

    // operation mix follows the phase: 0 grow, 1 mixed, 2 shrink
    function automatic op_t pick_op(int mode);
        int r;
        r = $urandom_range(0, 99);
        case (mode)
            0:       return (r < 45) ? OP_APPEND : (r < 75) ? OP_INSERT :
                            (r < 88) ? OP_READ : OP_DELETE;
            2:       return (r < 55) ? OP_DELETE : (r < 75) ? OP_READ :
                            (r < 90) ? OP_INSERT : OP_APPEND;
            default: return op_t'(r % 4);
        endcase
    endfunction

    // mostly legal indexes, some at the count, some anywhere
    function automatic int pick_position(op_t f, int len);
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
        begin
            if (f == OP_INSERT)
                return $urandom_range(0, len);
            return (len == 0) ? 0 : $urandom_range(0, len - 1);
        end
        else if (r < 90)
            return len;
        return $urandom_range(0, DEPTH);
    endfunction

    // stimulus
    initial
    begin
        int   k;
        int   mode;
        op_t  f;
        rst_n        = 1'b0;
        calm         = 1'b0;
        req_if.valid = 1'b0;
        req_if.data  = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed: empty list, bad indexes, extremes, shifting
        issue(OP_DELETE, 0, 32'h0);
        issue(OP_READ, 0, 32'hFFFF_FFFF);
        issue(OP_INSERT, 1, 32'h1234_5678);
        issue(OP_INSERT, DEPTH, 32'h0);
        issue(OP_INSERT, 0, 32'h8000_0000);
        issue(OP_APPEND, 127, 32'h7FFF_FFFF);
        issue(OP_APPEND, 0, 32'hFFFF_FFFF);
        issue(OP_INSERT, 1, 32'h0);
        issue(OP_INSERT, 4, 32'h5555_5555);
        issue(OP_READ, 0, 32'h0);
        issue(OP_READ, 1, 32'h0);
        issue(OP_READ, 2, 32'h0);
        issue(OP_READ, 3, 32'h0);
        issue(OP_READ, 4, 32'h0);
        issue(OP_READ, DEPTH, 32'h0);
        issue(OP_DELETE, 5, 32'h0);
        issue(OP_DELETE, 0, 32'hFFFF_FFFF);
        issue(OP_READ, 0, 32'h0);
        issue(OP_DELETE, 3, 32'h0);
        issue(OP_READ, 2, 32'h0);
        issue(OP_INSERT, 0, 32'hAAAA_AAAA);
        issue(OP_READ, 0, 32'h0);
        issue(OP_DELETE, DEPTH, 32'h0);
        wait_drained();

        // random phases
        for (k = 0; k < RANDOM_WORDS; k++)
        begin
            mode = (k / 120) % 3;
            calm = (k >= 700) && (k < 1000);
            f    = pick_op(mode);
            issue(f, pick_position(f, sb.len), pick_value());
            if ((k % 500) == 499)
                wait_drained();
        end

        // finish: everything back, then a short tail
        calm = 1'b0;
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/iida_pkg.sv
src/iida_stream_if.sv
src/iida_cell.sv
src/indexed_insert_delete_array_core.sv
dv/indexed_insert_delete_array_core_tb.sv
